/* rtl/i2cq_pkg.sv */
// Shared types and constants of the I2C master transmit queue sequencer.
package i2cq_pkg;

	localparam int OP_W        = 3;
	localparam int ADDR_W      = 7;
	localparam int DATA_W      = 8;
	localparam int LEN_OUT_W   = 5;
	localparam int DIAG_W      = 32;
	localparam int SEL_W       = 2;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 64;
	localparam int CMD_DEPTH   = 2;
	localparam int DIAG_NUM    = 4;

	localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
	localparam logic [OP_W-1:0] OP_DRAIN = 3'd1;
	localparam logic [OP_W-1:0] OP_INTR  = 3'd2;
	localparam logic [OP_W-1:0] OP_OPEN  = 3'd3;
	localparam logic [OP_W-1:0] OP_CLOSE = 3'd4;

	localparam logic [SEL_W-1:0] DIAG_BUSY = 2'd0;
	localparam logic [SEL_W-1:0] DIAG_NACK = 2'd1;
	localparam logic [SEL_W-1:0] DIAG_ARB  = 2'd2;
	localparam logic [SEL_W-1:0] DIAG_SENT = 2'd3;

	typedef enum logic [2:0] {
		K_PUSH  = 3'd0,
		K_DRAIN = 3'd1,
		K_INTR  = 3'd2,
		K_OPEN  = 3'd3,
		K_CLOSE = 3'd4,
		K_NONE  = 3'd5
	} kind_t;

	typedef struct packed {
		logic              pad;
		logic [SEL_W-1:0]  sel;
		logic              ardy;
		logic              xrdy;
		logic              arb;
		logic              nack;
		logic              slave;
		logic              busy;
		logic [DATA_W-1:0] data;
		logic [ADDR_W-1:0] addr;
	} in_word_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              last;
		logic              busy;
		logic              slave;
		logic              nack;
		logic              arb;
		logic              xrdy;
		logic              ardy;
		logic [SEL_W-1:0]  sel;
	} cmd_t;

	typedef struct packed {
		logic [DIAG_W-1:0]    diag;
		logic                 busy;
		logic                 restore;
		logic                 stop;
		logic [DATA_W-1:0]    tx_byte;
		logic                 tx_valid;
		logic [LEN_OUT_W-1:0] len;
		logic [ADDR_W-1:0]    target;
		logic                 start;
		logic                 accepted;
	} res_t;

	localparam int RES_W = $bits(res_t);

endpackage

/* rtl/i2c_master_tx_queue_sequencer.sv */
// Top level of the I2C master transmit queue sequencer.
//
//  channel  dir  handshake           payload
//  s_*      in   s_tvalid/s_tready   tuser opcode, tlast byte_last, tdata event fields
//  m_*      out  m_tvalid/m_tready   tdata result fields, one word per input word
//
// The sequencer handles a word as a command latch with memory reads, then an execute step.
// A committed push then copies the staged bytes into the queue memory,
// and a pop copies them into the current-message buffer.
// The front register and a two-entry command queue keep taking words, until they are full,
// while a result waits in the output register. Reset is asynchronous; message memories are not cleared.
module i2c_master_tx_queue_sequencer import i2cq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int MAX_MESSAGE = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // slave_address, data_byte, bus_busy, slave_open,
	                                         // stat_nack, stat_arb_lost, stat_xrdy, stat_ardy,
	                                         // diag_select, zero pad
	input  logic [OP_W-1:0]        s_tuser,  // opcode
	input  logic                   s_tlast,  // byte_last
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // accepted, start_transfer, target_address,
	                                         // transfer_length, tx_valid, tx_byte, issue_stop,
	                                         // restore_slave, master_busy, diag_value, zero pad
);

	logic fe_valid, fe_ready;
	cmd_t fe_cmd;
	logic bk_valid, bk_ready;
	cmd_t bk_cmd;
	res_t res;

	i2cq_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready),
		.cmd       (fe_cmd)
	);

	i2cq_cmd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_cmd    (fe_cmd),
		.out_valid (bk_valid),
		.out_ready (bk_ready),
		.out_cmd   (bk_cmd)
	);

	i2cq_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_MESSAGE (MAX_MESSAGE)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (bk_valid),
		.cmd_ready (bk_ready),
		.cmd       (bk_cmd),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res       (res)
	);

	assign m_tdata = OUT_TDATA_W'(res);

endmodule

/* rtl/i2cq_front.sv */
// Input stage: accept stream words and classify them into commands.
module i2cq_front import i2cq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TDATA_W-1:0] s_tdata,  // slave_address, data_byte, bus_busy, slave_open,
	                                        // stat_nack, stat_arb_lost, stat_xrdy, stat_ardy,
	                                        // diag_select, zero pad
	input  logic [OP_W-1:0]       s_tuser,  // opcode
	input  logic                  s_tlast,  // byte_last
	output logic                  cmd_valid,
	input  logic                  cmd_ready,
	output cmd_t                  cmd
);

	logic     vld_s1;
	cmd_t     cmd_s1;
	cmd_t     dec;
	in_word_t w;
	logic     accept;

	assign w        = in_word_t'(s_tdata);
	assign s_tready = !vld_s1 || cmd_ready;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		dec.addr  = w.addr;
		dec.data  = w.data;
		dec.last  = s_tlast;
		dec.busy  = w.busy;
		dec.slave = w.slave;
		dec.nack  = w.nack;
		dec.arb   = w.arb;
		dec.xrdy  = w.xrdy;
		dec.ardy  = w.ardy;
		dec.sel   = w.sel;
		unique case (s_tuser)
			OP_PUSH:  dec.kind = K_PUSH;
			OP_DRAIN: dec.kind = K_DRAIN;
			OP_INTR:  dec.kind = K_INTR;
			OP_OPEN:  dec.kind = K_OPEN;
			OP_CLOSE: dec.kind = K_CLOSE;
			default:  dec.kind = K_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (cmd_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= dec;
		end
	end

	assign cmd_valid = vld_s1;
	assign cmd       = cmd_s1;

endmodule

/* rtl/i2cq_cmd_fifo.sv */
// Short command queue between the front end and the sequencer.
module i2cq_cmd_fifo import i2cq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	localparam int PW = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam logic [PW-1:0] LAST_P = PW'(CMD_DEPTH - 1);

	cmd_t          fifo_q [CMD_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = cnt_q != (PW+1)'(CMD_DEPTH);
	assign out_valid = cnt_q != '0;
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_cmd   = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == LAST_P) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == LAST_P) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_cmd;
		end
	end

endmodule

/* rtl/i2cq_back.sv */
// Sequencer: message queue, current transfer, counters and result register.
module i2cq_back import i2cq_pkg::*; #(
	parameter int QUEUE_DEPTH = 64,
	parameter int MAX_MESSAGE = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t res
);

	localparam int SW     = $clog2(QUEUE_DEPTH);
	localparam int IW     = (MAX_MESSAGE > 1) ? $clog2(MAX_MESSAGE) : 1;
	localparam int LW     = $clog2(MAX_MESSAGE + 2);
	localparam int QBYTES = QUEUE_DEPTH * MAX_MESSAGE;
	localparam int QAW    = $clog2(QBYTES);
	localparam logic [SW-1:0] LAST_SLOT = SW'(QUEUE_DEPTH - 1);
	localparam logic [LW-1:0] MAX_L     = LW'(MAX_MESSAGE);

	typedef enum logic [3:0] {
		B_CMD  = 4'b0001,
		B_EXEC = 4'b0010,
		B_STG  = 4'b0100,
		B_POP  = 4'b1000
	} bstate_t;

	typedef enum logic [2:0] {
		SEQ_IDLE    = 3'b001,
		SEQ_SENDING = 3'b010,
		SEQ_WAIT    = 3'b100
	} seq_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LW-1:0]     len;
	} meta_t;

	bstate_t           st_q;
	seq_t              seq_q, seq_d;
	logic              is_open_q, is_open_d;
	logic [SW-1:0]     head_q, head_d, tail_q, tail_d;
	logic              head_wr_q, head_wr_d, tail_wr_q, tail_wr_d;
	logic [LW-1:0]     stg_cnt_q, stg_cnt_d, stg_inc;
	logic [LW-1:0]     cur_len_q, cur_len_d;
	logic [LW-1:0]     bp_q, bp_d, bp_inc;
	logic [ADDR_W-1:0] cur_addr_q, cur_addr_d;
	logic [DIAG_W-1:0] diag_q [DIAG_NUM];
	logic [DIAG_W-1:0] diag_d [DIAG_NUM];
	cmd_t              cmd_q;
	logic [LW-1:0]     cp_q, cp_len_q, cp_len_d, cp_wm1;
	logic [SW-1:0]     cp_slot_q, cp_slot_d;
	logic              cp_lt;
	logic [QAW-1:0]    qb_base, qb_ra, qb_wa;
	res_t              res_q, res_d;
	logic              out_v_q;
	logic              exec_fire;
	logic              go_stg, go_pop;
	logic              full, empty;
	logic              stage_we, meta_we;
	meta_t             meta_wd;

	logic [DATA_W-1:0] stage_mem [MAX_MESSAGE];
	logic [DATA_W-1:0] cur_mem [MAX_MESSAGE];
	logic [DATA_W-1:0] q_mem [QBYTES];
	meta_t             meta_mem [QUEUE_DEPTH];
	logic [DATA_W-1:0] stage_rd_q, cur_rd_q, q_rd_q;
	meta_t             meta_rd_q;

	assign cmd_ready = st_q == B_CMD;
	assign exec_fire = (st_q == B_EXEC) && (!out_v_q || m_tready);
	assign full      = (head_q == tail_q) && (head_wr_q != tail_wr_q);
	assign empty     = (head_q == tail_q) && (head_wr_q == tail_wr_q);
	assign stg_inc   = (stg_cnt_q <= MAX_L) ? stg_cnt_q + 1'b1 : stg_cnt_q;
	assign bp_inc    = bp_q + 1'b1;
	assign cp_lt     = cp_q < cp_len_q;
	assign cp_wm1    = cp_q - 1'b1;
	assign qb_base   = QAW'(cp_slot_q) * QAW'(MAX_MESSAGE);
	assign qb_ra     = qb_base + QAW'(cp_q);
	assign qb_wa     = qb_base + QAW'(cp_wm1);

	always_comb begin
		seq_d      = seq_q;
		is_open_d  = is_open_q;
		head_d     = head_q;
		head_wr_d  = head_wr_q;
		tail_d     = tail_q;
		tail_wr_d  = tail_wr_q;
		stg_cnt_d  = stg_cnt_q;
		cur_len_d  = cur_len_q;
		cur_addr_d = cur_addr_q;
		bp_d       = bp_q;
		cp_len_d   = cp_len_q;
		cp_slot_d  = cp_slot_q;
		for (int i = 0; i < DIAG_NUM; i++) begin
			diag_d[i] = diag_q[i];
		end
		res_d    = '0;
		stage_we = 1'b0;
		meta_we  = 1'b0;
		meta_wd  = '{addr: cmd_q.addr, len: stg_inc};
		go_stg   = 1'b0;
		go_pop   = 1'b0;
		unique case (cmd_q.kind)
			K_PUSH: begin
				stage_we  = stg_cnt_q < MAX_L;
				stg_cnt_d = stg_inc;
				if (cmd_q.last) begin
					stg_cnt_d = '0;
					if (is_open_q && !full && stg_inc <= MAX_L) begin
						meta_we        = 1'b1;
						res_d.accepted = 1'b1;
						tail_d         = (tail_q == LAST_SLOT) ? '0 : tail_q + 1'b1;
						tail_wr_d      = (tail_q == LAST_SLOT) ? !tail_wr_q : tail_wr_q;
						cp_len_d       = stg_inc;
						cp_slot_d      = tail_q;
						go_stg         = 1'b1;
					end
				end
			end
			K_DRAIN: begin
				if (is_open_q && seq_q == SEQ_IDLE) begin
					priority if (cmd_q.busy) begin
						diag_d[DIAG_BUSY] = diag_q[DIAG_BUSY] + 1'b1;
						res_d.restore     = cmd_q.slave;
					end else if (empty) begin
						res_d.restore = cmd_q.slave;
					end else begin
						cur_addr_d   = meta_rd_q.addr;
						cur_len_d    = meta_rd_q.len;
						head_d       = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
						head_wr_d    = (head_q == LAST_SLOT) ? !head_wr_q : head_wr_q;
						bp_d         = '0;
						seq_d        = SEQ_SENDING;
						res_d.start  = 1'b1;
						res_d.target = meta_rd_q.addr;
						res_d.len    = LEN_OUT_W'(meta_rd_q.len);
						cp_len_d     = meta_rd_q.len;
						cp_slot_d    = head_q;
						go_pop       = 1'b1;
					end
				end
			end
			K_INTR: begin
				if (is_open_q && seq_q != SEQ_IDLE) begin
					priority if (cmd_q.nack) begin
						diag_d[DIAG_NACK] = diag_q[DIAG_NACK] + 1'b1;
						res_d.stop        = 1'b1;
						seq_d             = SEQ_IDLE;
						res_d.restore     = cmd_q.slave;
					end else if (cmd_q.arb) begin
						diag_d[DIAG_ARB] = diag_q[DIAG_ARB] + 1'b1;
						seq_d            = SEQ_IDLE;
						res_d.restore    = cmd_q.slave;
					end else begin
						if (cmd_q.xrdy && bp_q < cur_len_q && bp_q < MAX_L) begin
							res_d.tx_valid = 1'b1;
							res_d.tx_byte  = cur_rd_q;
							bp_d           = bp_inc;
							if (bp_inc >= cur_len_q) begin
								seq_d = SEQ_WAIT;
							end
						end
						if (cmd_q.ardy) begin
							diag_d[DIAG_SENT] = diag_q[DIAG_SENT] + 1'b1;
							seq_d             = SEQ_IDLE;
							res_d.restore     = cmd_q.slave;
						end
					end
				end
			end
			K_OPEN: begin
				if (!is_open_q) begin
					is_open_d  = 1'b1;
					seq_d      = SEQ_IDLE;
					head_d     = '0;
					head_wr_d  = 1'b0;
					tail_d     = '0;
					tail_wr_d  = 1'b0;
					stg_cnt_d  = '0;
					cur_addr_d = '0;
					cur_len_d  = '0;
					bp_d       = '0;
					for (int i = 0; i < DIAG_NUM; i++) begin
						diag_d[i] = '0;
					end
				end
			end
			K_CLOSE: begin
				if (is_open_q) begin
					is_open_d     = 1'b0;
					seq_d         = SEQ_IDLE;
					res_d.restore = cmd_q.slave;
				end
			end
			K_NONE: begin
			end
			default: begin
			end
		endcase
		res_d.busy = is_open_d && seq_d != SEQ_IDLE;
		res_d.diag = diag_d[cmd_q.sel];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_CMD;
			seq_q      <= SEQ_IDLE;
			is_open_q  <= 1'b0;
			head_q     <= '0;
			head_wr_q  <= 1'b0;
			tail_q     <= '0;
			tail_wr_q  <= 1'b0;
			stg_cnt_q  <= '0;
			cur_len_q  <= '0;
			cur_addr_q <= '0;
			bp_q       <= '0;
			cp_q       <= '0;
			cp_len_q   <= '0;
			cp_slot_q  <= '0;
			out_v_q    <= 1'b0;
			for (int i = 0; i < DIAG_NUM; i++) begin
				diag_q[i] <= '0;
			end
		end else begin
			if (exec_fire) begin
				out_v_q <= 1'b1;
			end else if (m_tready) begin
				out_v_q <= 1'b0;
			end
			unique case (st_q)
				B_CMD: begin
					if (cmd_valid) begin
						st_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (exec_fire) begin
						seq_q      <= seq_d;
						is_open_q  <= is_open_d;
						head_q     <= head_d;
						head_wr_q  <= head_wr_d;
						tail_q     <= tail_d;
						tail_wr_q  <= tail_wr_d;
						stg_cnt_q  <= stg_cnt_d;
						cur_len_q  <= cur_len_d;
						cur_addr_q <= cur_addr_d;
						bp_q       <= bp_d;
						cp_len_q   <= cp_len_d;
						cp_slot_q  <= cp_slot_d;
						cp_q       <= '0;
						for (int i = 0; i < DIAG_NUM; i++) begin
							diag_q[i] <= diag_d[i];
						end
						priority if (go_stg) begin
							st_q <= B_STG;
						end else if (go_pop) begin
							st_q <= B_POP;
						end else begin
							st_q <= B_CMD;
						end
					end
				end
				B_STG, B_POP: begin
					cp_q <= cp_q + 1'b1;
					if (cp_q == cp_len_q) begin
						st_q <= B_CMD;
					end
				end
				default: begin
					st_q <= B_CMD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_CMD && cmd_valid) begin
			cmd_q <= cmd;
		end
		if (exec_fire) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && stage_we) begin
			stage_mem[stg_cnt_q[IW-1:0]] <= cmd_q.data;
		end
		if (st_q == B_STG && cp_lt) begin
			stage_rd_q <= stage_mem[cp_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_STG && cp_q != '0) begin
			q_mem[qb_wa] <= stage_rd_q;
		end
		if (st_q == B_POP && cp_lt) begin
			q_rd_q <= q_mem[qb_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == B_POP && cp_q != '0) begin
			cur_mem[cp_wm1[IW-1:0]] <= q_rd_q;
		end
		if (st_q == B_CMD && bp_q < MAX_L) begin
			cur_rd_q <= cur_mem[bp_q[IW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire && meta_we) begin
			meta_mem[tail_q] <= meta_wd;
		end
		if (st_q == B_CMD) begin
			meta_rd_q <= meta_mem[head_q];
		end
	end

	assign m_tvalid = out_v_q;
	assign res      = res_q;

endmodule

/* rtl/i2cq_checker.sv */
// Port-level assertions for the I2C master transmit queue sequencer, with bind.
module i2cq_checker import i2cq_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	res_t r;

	assign r = res_t'(m_tdata[RES_W-1:0]);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.start |-> r.busy && !r.accepted)
		else $error("start without busy sequencer");

	a_tx_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.tx_valid |-> !r.start && !r.stop)
		else $error("byte emitted together with start or stop");

	a_stop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r.stop |-> !r.busy)
		else $error("stop issued while still busy");

	a_no_start_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r.start |-> r.target == '0 && r.len == '0)
		else $error("transfer fields set without start");

endmodule

bind i2c_master_tx_queue_sequencer i2cq_checker u_chk (.*);

/* sim/tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master transmit queue sequencer.
module tb;
	import i2cq_pkg::*;

	localparam int QD       = 64;
	localparam int MAXM     = 16;
	localparam int N_RANDOM = 650;
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef enum logic [1:0] {SQ_IDLE, SQ_SEND, SQ_WAIT_ARDY} seq_t;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              last;
		logic              busy;
		logic              slave;
		logic              nack;
		logic              arb;
		logic              xrdy;
		logic              ardy;
		logic [SEL_W-1:0]  sel;
	} ev_t;

	class xfer_scoreboard;
		res_t       due_q[$];
		int         errors;
		bit         is_open;
		seq_t       seq;
		logic [7:0] q_bytes [QD*MAXM];
		logic [6:0] q_addr [QD];
		logic [4:0] q_len [QD];
		logic [7:0] stage [MAXM];
		logic [7:0] cur [MAXM];
		bit [6:0]   head;
		bit [6:0]   tail;
		int         stage_cnt;
		logic [6:0] cur_addr;
		logic [4:0] cur_len;
		int         pos;
		bit [31:0]  diag [DIAG_NUM];

		function new();
			errors  = 0;
			is_open = 0;
			clear();
		endfunction

		function void clear();
			seq       = SQ_IDLE;
			head      = 0;
			tail      = 0;
			stage_cnt = 0;
			cur_addr  = 0;
			cur_len   = 0;
			pos       = 0;
			foreach (diag[i]) diag[i] = 0;
		endfunction

		function bit [6:0] fill();
			return tail - head;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void note_event(ev_t w);
			res_t r;
			int   len;
			int   slot;
			r = '0;
			case (w.op)
			OP_PUSH: begin
				if (stage_cnt < MAXM)
					stage[stage_cnt] = w.data;
				if (stage_cnt <= MAXM)
					stage_cnt++;
				if (w.last) begin
					len = stage_cnt;
					if (is_open && fill() < QD && len <= MAXM) begin
						slot = tail % QD;
						for (int i = 0; i < len; i++)
							q_bytes[slot*MAXM+i] = stage[i];
						q_addr[slot] = w.addr;
						q_len[slot]  = 5'(len);
						tail++;
						r.accepted = 1'b1;
					end
					stage_cnt = 0;
				end
			end
			OP_DRAIN: begin
				if (is_open && seq == SQ_IDLE) begin
					if (w.busy) begin
						diag[DIAG_BUSY]++;
						r.restore = w.slave;
					end else if (fill() == 0) begin
						r.restore = w.slave;
					end else begin
						slot     = head % QD;
						cur_addr = q_addr[slot];
						cur_len  = q_len[slot];
						for (int i = 0; i < cur_len; i++)
							cur[i] = q_bytes[slot*MAXM+i];
						head++;
						pos      = 0;
						seq      = SQ_SEND;
						r.start  = 1'b1;
						r.target = cur_addr;
						r.len    = cur_len;
					end
				end
			end
			OP_INTR: begin
				if (is_open && seq != SQ_IDLE) begin
					if (w.nack) begin
						diag[DIAG_NACK]++;
						r.stop    = 1'b1;
						seq       = SQ_IDLE;
						r.restore = w.slave;
					end else if (w.arb) begin
						diag[DIAG_ARB]++;
						seq       = SQ_IDLE;
						r.restore = w.slave;
					end else begin
						if (w.xrdy && pos < cur_len) begin
							r.tx_valid = 1'b1;
							r.tx_byte  = cur[pos];
							pos++;
							if (pos >= cur_len)
								seq = SQ_WAIT_ARDY;
						end
						if (w.ardy) begin
							diag[DIAG_SENT]++;
							seq       = SQ_IDLE;
							r.restore = w.slave;
						end
					end
				end
			end
			OP_OPEN: begin
				if (!is_open) begin
					clear();
					is_open = 1;
				end
			end
			OP_CLOSE: begin
				if (is_open) begin
					is_open   = 0;
					seq       = SQ_IDLE;
					r.restore = w.slave;
				end
			end
			default: ;
			endcase
			r.busy = is_open && seq != SQ_IDLE;
			r.diag = diag[w.sel];
			due_q.push_back(r);
		endfunction

		function void cmp_field(string name, logic [DIAG_W-1:0] want, logic [DIAG_W-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(res_t got);
			res_t want;
			if (due_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
				return;
			end
			want = due_q.pop_front();
			cmp_field("accepted", want.accepted, got.accepted);
			cmp_field("start_transfer", want.start, got.start);
			cmp_field("target_address", want.target, got.target);
			cmp_field("transfer_length", want.len, got.len);
			cmp_field("tx_valid", want.tx_valid, got.tx_valid);
			cmp_field("tx_byte", want.tx_byte, got.tx_byte);
			cmp_field("issue_stop", want.stop, got.stop);
			cmp_field("restore_slave", want.restore, got.restore);
			cmp_field("master_busy", want.busy, got.busy);
			cmp_field("diag_value", want.diag, got.diag);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [OP_W-1:0]        s_tuser  = '0;
	logic                   s_tlast  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	xfer_scoreboard sb;
	bit             calm;
	int             words_sent;

	i2c_master_tx_queue_sequencer #(
		.QUEUE_DEPTH(QD),
		.MAX_MESSAGE(MAXM)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int msg_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return $urandom_range(1, 4);
		if (r < 87)
			return $urandom_range(5, MAXM - 1);
		if (r < 94)
			return MAXM;
		return $urandom_range(MAXM + 1, MAXM + 4);
	endfunction

	function automatic ev_t rand_ev(logic [OP_W-1:0] op);
		ev_t         w;
		logic [31:0] r;
		r    = $urandom;
		w    = r[$bits(ev_t)-1:0];
		w.op = op;
		return w;
	endfunction

	// flags: {last, busy, slave, nack, arb, xrdy, ardy}
	function automatic ev_t mk(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
			logic [DATA_W-1:0] data, logic [6:0] flags, logic [SEL_W-1:0] sel);
		ev_t w;
		w      = '0;
		w.op   = op;
		w.addr = addr;
		w.data = data;
		w.sel  = sel;
		{w.last, w.busy, w.slave, w.nack, w.arb, w.xrdy, w.ardy} = flags;
		return w;
	endfunction

	task automatic send_word(ev_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= w.op;
		s_tlast  <= w.last;
		s_tdata  <= {1'b0, w.sel, w.ardy, w.xrdy, w.arb, w.nack, w.slave, w.busy,
			w.data, w.addr};
		do @(posedge clk); while (!s_tready);
		sb.note_event(w);
		if (w.op <= OP_CLOSE)
			words_sent++;
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic push_message(int len);
		ev_t w;
		for (int i = 0; i < len; i++) begin
			w      = rand_ev(OP_PUSH);
			w.last = (i == len - 1);
			send_word(w);
		end
	endtask

	task automatic run_transfer();
		ev_t w;
		int  n;
		w      = rand_ev(OP_DRAIN);
		w.busy = ($urandom_range(0, 9) == 0);
		send_word(w);
		n = $urandom_range(1, MAXM + 1);
		repeat (n) begin
			w      = rand_ev(OP_INTR);
			w.xrdy = ($urandom_range(0, 9) != 0);
			w.nack = ($urandom_range(0, 39) == 0);
			w.arb  = ($urandom_range(0, 39) == 0);
			w.ardy = ($urandom_range(0, 29) == 0);
			send_word(w);
		end
		w      = rand_ev(OP_INTR);
		w.nack = 1'b0;
		w.arb  = 1'b0;
		w.ardy = 1'b1;
		send_word(w);
	endtask

	initial begin
		int r;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
				r = pick_gap();
				if (r > 0) begin
					m_tready <= 1'b0;
					repeat (r - 1) @(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_outcome(res_t'(m_tdata[RES_W-1:0]));
	end

	initial begin
		int pick;
		bit filled;
		sb         = new();
		calm       = 1'b0;
		filled     = 1'b0;
		words_sent = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0000000, DIAG_BUSY));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0000010, DIAG_SENT));
		send_word(mk(OP_CLOSE, 7'h00, 8'h00, 7'b0010000, DIAG_BUSY));
		send_word(mk(OP_PUSH, 7'h55, 8'hA5, 7'b1000000, DIAG_BUSY));
		send_word(mk(OP_OPEN, 7'h00, 8'h00, 7'b0000000, DIAG_BUSY));
		send_word(mk(OP_OPEN, 7'h00, 8'h00, 7'b0010000, DIAG_BUSY));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0011111, DIAG_NACK));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0010000, DIAG_BUSY));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0110000, DIAG_BUSY));
		send_word(mk(OP_PUSH, 7'h00, 8'h00, 7'b1000000, DIAG_BUSY));
		send_word(mk(OP_PUSH, 7'h00, 8'hFF, 7'b0000000, DIAG_BUSY));
		send_word(mk(OP_PUSH, 7'h7F, 8'h00, 7'b1000000, DIAG_BUSY));
		send_word(mk(OP_SPARE_LO, 7'h7F, 8'hFF, 7'b1111111, DIAG_SENT));
		send_word(mk(OP_SPARE_HI, 7'h7F, 8'hFF, 7'b1111111, DIAG_ARB));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0000000, DIAG_BUSY));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0010000, DIAG_BUSY));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0010011, DIAG_SENT));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0000000, DIAG_SENT));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0000010, DIAG_SENT));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0000010, DIAG_SENT));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0000010, DIAG_SENT));
		send_word(mk(OP_INTR, 7'h00, 8'h00, 7'b0011111, DIAG_NACK));
		send_word(mk(OP_DRAIN, 7'h00, 8'h00, 7'b0000000, DIAG_NACK));
		send_word(mk(OP_CLOSE, 7'h00, 8'h00, 7'b0010000, DIAG_BUSY));
		send_word(mk(OP_OPEN, 7'h00, 8'h00, 7'b0000000, DIAG_BUSY));

		words_sent = 0;
		while (words_sent < N_RANDOM) begin
			if ($urandom_range(0, 9) == 0)
				calm = !calm;
			if (!sb.is_open && $urandom_range(0, 3) != 0)
				send_word(rand_ev(OP_OPEN));
			if (!filled && words_sent >= N_RANDOM / 2) begin
				filled = 1'b1;
				send_word(rand_ev(OP_OPEN));
				repeat (QD + 2) push_message(1);
				wait_results();
			end
			pick = $urandom_range(0, 99);
			if (pick < 40)
				push_message(msg_len());
			else if (pick < 75)
				run_transfer();
			else if (pick < 90)
				send_word(rand_ev(OP_W'($urandom_range(OP_PUSH, OP_SPARE_HI))));
			else if (pick < 95) begin
				send_word(rand_ev(OP_CLOSE));
				send_word(rand_ev(OP_OPEN));
			end else
				repeat ($urandom_range(2, 6)) send_word(rand_ev(OP_DRAIN));
		end

		wait_results();
		repeat (50) @(posedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
